/* hdl/sbm_pkg.sv */
// Shared constants, types and state codes for the stereo SAD block matcher.
`default_nettype none
package sbm_pkg;

    // Default sizes handed to the top-level parameters
    localparam int WINDOW_SIZE_DEF    = 7;
    localparam int MAX_WIDTH_DEF      = 1024;
    localparam int MAX_CANDIDATES_DEF = 64;

    // Field widths fixed by the stream format and the parameter ranges
    localparam int PIX_W  = 8;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 12;   // columns up to the largest supported width
    localparam int SLOT_W = 4;    // row slots up to the largest window
    localparam int K_W    = 8;    // shift index up to the largest candidate count

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_CANDIDATE_COUNT = 2'd1;
    localparam logic [1:0] REG_SCALE_FACTOR    = 2'd2;

    localparam logic [10:0] IMAGE_WIDTH_RST     = 11'd384;
    localparam logic [6:0]  CANDIDATE_COUNT_RST = 7'd15;
    localparam logic [7:0]  SCALE_FACTOR_RST    = 8'd15;

    // One classified pixel pair on its way from front to back
    typedef struct packed {
        logic [PIX_W-1:0]  left_pixel;
        logic [PIX_W-1:0]  right_pixel;
        logic [SLOT_W-1:0] wr_slot;
        logic [COL_W-1:0]  wr_col;
        logic              produce;
        logic [SLOT_W-1:0] top_slot;
        logic [COL_W-1:0]  anchor_col;
        logic [ROW_W-1:0]  anchor_row;
        logic [K_W-1:0]    last_k;
    } sbm_job_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_DONE
    } sbm_bk_state_t;

endpackage
`default_nettype wire

/* hdl/sbm_front.sv */
// Front end: accepts pixel pairs, tracks raster position and classifies windows.
`default_nettype none
module sbm_front
    import sbm_pkg::*;
#(
    parameter int WINDOW_SIZE    = WINDOW_SIZE_DEF,
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic [10:0] image_width,
    input  wire logic [6:0]  candidate_count,
    input  wire logic        q_full,
    output logic             q_push,
    output sbm_job_t         q_job
);

    localparam logic [ROW_W-1:0]  ROW_MAX = {ROW_W{1'b1}};
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SIZE - 1);
    localparam logic [12:0] W_MAX = 13'(MAX_WIDTH);
    localparam logic [8:0]  C_MAX = 9'(MAX_CANDIDATES);

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [12:0]       eff_w;
    logic [ROW_W-1:0]  pre_row;
    logic [COL_W-1:0]  pre_col;
    logic [SLOT_W-1:0] pre_slot;
    logic [12:0]       col_inc;
    logic [8:0]        cands;
    logic [8:0]        last_c;
    logic [COL_W-1:0]  lc;
    logic              accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    // Clamp width to 1 .. MAX_WIDTH
    always_comb begin
        if (image_width == 11'd0) begin
            eff_w = 13'd1;
        end else if (13'(image_width) > W_MAX) begin
            eff_w = W_MAX;
        end else begin
            eff_w = 13'(image_width);
        end
    end

    // Position of this pixel
    always_comb begin
        pre_row  = row_reg;
        pre_col  = col_reg;
        pre_slot = slot_reg;
        if (s_tuser) begin
            pre_row  = '0;
            pre_col  = '0;
            pre_slot = '0;
        end else if (13'(col_reg) >= eff_w) begin
            pre_col  = '0;
            pre_row  = row_reg + 1'b1;
            if (row_reg == ROW_MAX || slot_reg == LAST_SLOT) begin
                pre_slot = '0;
            end else begin
                pre_slot = slot_reg + 1'b1;
            end
        end
    end

    // Position of the following pixel
    always_comb begin
        col_inc   = 13'(pre_col) + 13'd1;
        row_next  = pre_row;
        slot_next = pre_slot;
        col_next  = col_inc[COL_W-1:0];
        if (col_inc >= eff_w) begin
            col_next = '0;
            row_next = pre_row + 1'b1;
            if (pre_row == ROW_MAX || pre_slot == LAST_SLOT) begin
                slot_next = '0;
            end else begin
                slot_next = pre_slot + 1'b1;
            end
        end
    end

    // Shift range: clamp count, never reach past column zero
    always_comb begin
        if (candidate_count == 7'd0) begin
            cands = 9'd1;
        end else if (9'(candidate_count) > C_MAX) begin
            cands = C_MAX;
        end else begin
            cands = 9'(candidate_count);
        end
        lc     = pre_col - COL_W'(WINDOW_SIZE - 1);
        last_c = cands - 9'd1;
        if (13'(last_c) > 13'(lc)) begin
            last_c = 9'(lc);
        end
    end

    // Job for the back end
    always_comb begin
        q_job.left_pixel  = s_tdata[7:0];
        q_job.right_pixel = s_tdata[15:8];
        q_job.wr_slot     = pre_slot;
        q_job.wr_col      = pre_col;
        q_job.produce     = (pre_row >= ROW_W'(WINDOW_SIZE - 1))
                            && (pre_col >= COL_W'(WINDOW_SIZE - 1));
        q_job.top_slot    = (pre_slot == LAST_SLOT) ? '0 : pre_slot + 1'b1;
        q_job.anchor_col  = lc;
        q_job.anchor_row  = pre_row - ROW_W'(WINDOW_SIZE - 1);
        q_job.last_k      = last_c[K_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end else if (accept) begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            slot_reg <= slot_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/sbm_queue.sv */
// Two-entry job queue between the front and back ends.
`default_nettype none
module sbm_queue
    import sbm_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire sbm_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          empty,
    output sbm_job_t      head_job
);

    sbm_job_t   entry_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_job = entry_reg[rp_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wp_reg] <= push_job;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/sbm_back.sv */
// Back end: line stores, SAD sequencer over shifts and output register.
`default_nettype none
module sbm_back
    import sbm_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_empty,
    input  wire sbm_job_t    q_job,
    output logic             q_pop,
    input  wire logic [7:0]  scale_factor,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata
);

    localparam int DEPTH = WINDOW_SIZE * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUM_W = $clog2(WINDOW_SIZE * WINDOW_SIZE * 255 + 1);
    localparam int UW    = $clog2(WINDOW_SIZE);
    localparam logic [UW-1:0]     LAST_UV   = UW'(WINDOW_SIZE - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SIZE - 1);

    logic [PIX_W-1:0] left_mem  [DEPTH];
    logic [PIX_W-1:0] right_mem [DEPTH];

    sbm_bk_state_t state_reg, state_next;
    sbm_job_t      job_reg;

    logic [UW-1:0]     u_reg, v_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [K_W-1:0]    k_reg;
    logic [PIX_W-1:0]  rd_l_reg, rd_r_reg;
    logic              rd_valid_reg, rd_endk_reg;
    logic [K_W-1:0]    rd_k_reg;
    logic [SUM_W-1:0]  acc_reg, best_sad_reg;
    logic [K_W-1:0]    best_k_reg;
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;

    logic              issue, load_out, end_v, end_u, end_all;
    logic [COL_W-1:0]  lcol, rcol;
    logic [AW-1:0]     wr_addr, rdl_addr, rdr_addr;
    logic [PIX_W-1:0]  diff;
    logic [SUM_W-1:0]  sum;
    logic [15:0]       prod;
    logic [7:0]        disp;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Scan position decode
    assign end_v   = (v_reg == LAST_UV);
    assign end_u   = (u_reg == LAST_UV);
    assign end_all = end_v && end_u && (k_reg == job_reg.last_k);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty && q_job.produce) begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (end_all) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: state_next = BK_DONE;
            BK_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        q_pop    = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE:  q_pop = !q_empty;
            BK_SCAN:  issue = 1'b1;
            BK_DRAIN: ;
            BK_DONE:  load_out = !m_tvalid_reg || m_tready;
            default:  ;
        endcase
    end

    // Addresses: row slot times MAX_WIDTH plus column
    always_comb begin
        lcol     = job_reg.anchor_col + COL_W'(v_reg);
        rcol     = lcol - COL_W'(k_reg);
        wr_addr  = AW'(q_job.wr_slot * MAX_WIDTH) + AW'(q_job.wr_col);
        rdl_addr = AW'(slot_reg * MAX_WIDTH) + AW'(lcol);
        rdr_addr = AW'(slot_reg * MAX_WIDTH) + AW'(rcol);
    end

    // Line stores
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            left_mem[wr_addr]  <= q_job.left_pixel;
            right_mem[wr_addr] <= q_job.right_pixel;
        end
        rd_l_reg <= left_mem[rdl_addr];
        rd_r_reg <= right_mem[rdr_addr];
    end

    // Absolute difference and running sum
    always_comb begin
        diff = (rd_l_reg > rd_r_reg) ? rd_l_reg - rd_r_reg : rd_r_reg - rd_l_reg;
        sum  = acc_reg + SUM_W'(diff);
    end

    // Saturated output value
    always_comb begin
        prod = 16'(best_k_reg) * 16'(scale_factor);
        disp = (prod > 16'd255) ? 8'd255 : prod[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Sequencer counters, compare and output payload
    always_ff @(posedge aclk) begin
        rd_endk_reg <= end_v && end_u;
        rd_k_reg    <= k_reg;
        if (q_pop) begin
            job_reg  <= q_job;
            slot_reg <= q_job.top_slot;
            u_reg    <= '0;
            v_reg    <= '0;
            k_reg    <= '0;
            acc_reg  <= '0;
        end else if (issue) begin
            if (end_v) begin
                v_reg <= '0;
                if (end_u) begin
                    u_reg    <= '0;
                    slot_reg <= job_reg.top_slot;
                    k_reg    <= k_reg + 1'b1;
                end else begin
                    u_reg    <= u_reg + 1'b1;
                    slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                end
            end else begin
                v_reg <= v_reg + 1'b1;
            end
        end
        if (rd_valid_reg) begin
            if (rd_endk_reg) begin
                acc_reg <= '0;
                if (rd_k_reg == '0 || sum < best_sad_reg) begin
                    best_sad_reg <= sum;
                    best_k_reg   <= rd_k_reg;
                end
            end else begin
                acc_reg <= sum;
            end
        end
        if (load_out) begin
            m_tdata_reg <= {4'd0, 10'(job_reg.anchor_col), job_reg.anchor_row, disp};
        end
    end

endmodule
`default_nettype wire

/* hdl/stereo_sad_block_match.sv */
// Stereo SAD block matcher top level: configuration registers and front/back wiring.
//
// Pixel pairs enter in raster order; each one whose position completes a
// WINDOW_SIZE x WINDOW_SIZE window yields one disparity result. The front end
// hands each pair to a two-entry queue. The back end stores it in the line
// memories and, for a complete window, runs a single read port per image
// through the search, one read per window pixel and shift 0 .. last_k, then
// drains and loads the output; last_k is the smaller of the anchor column and
// the clamped candidate_count - 1. Pairs that complete no window are only
// stored. The line memories need no clearing pass after reset.
`default_nettype none
module stereo_sad_block_match
    import sbm_pkg::*;
#(
    parameter int WINDOW_SIZE    = WINDOW_SIZE_DEF,
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Pixel input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] left_pixel, [15:8] right_pixel
    input  wire logic        s_tuser,   // [0] frame_start
    // Disparity output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] disparity_value, [17:8] anchor_row,
                                        // [27:18] anchor_col, [31:28] zero
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [10:0] image_width_reg;
    logic [6:0]  candidate_count_reg;
    logic [7:0]  scale_factor_reg;
    logic        wr_en;

    logic        q_push, q_full, q_pop, q_empty;
    sbm_job_t    push_job, head_job;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg     <= IMAGE_WIDTH_RST;
            candidate_count_reg <= CANDIDATE_COUNT_RST;
            scale_factor_reg    <= SCALE_FACTOR_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:     image_width_reg     <= pwdata[10:0];
                REG_CANDIDATE_COUNT: candidate_count_reg <= pwdata[6:0];
                REG_SCALE_FACTOR:    scale_factor_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:     prdata = 32'(image_width_reg);
            REG_CANDIDATE_COUNT: prdata = 32'(candidate_count_reg);
            REG_SCALE_FACTOR:    prdata = 32'(scale_factor_reg);
            default:             prdata = '0;
        endcase
    end

    sbm_front #(
        .WINDOW_SIZE    (WINDOW_SIZE),
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .image_width     (image_width_reg),
        .candidate_count (candidate_count_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_job           (push_job)
    );

    sbm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (head_job)
    );

    sbm_back #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_job        (head_job),
        .q_pop        (q_pop),
        .scale_factor (scale_factor_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
`default_nettype wire

/* hdl/sbm_checker.sv */
// Port-level checks for the stereo SAD block matcher, bound to the top level.
`default_nettype none
module sbm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        s_tready,
    input wire logic        pready
);

    // Result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // No result right after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:28] == 4'd0)
        else $error("result padding not zero");

    // Input side free again right after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // Register port never waits
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind stereo_sad_block_match sbm_checker u_sbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .s_tready (s_tready),
    .pready   (pready)
);
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the stereo SAD block matcher.
`timescale 1ns / 1ps
module tb_top;
    import sbm_pkg::*;

    localparam int WIN       = 7;
    localparam int MAXW      = 1024;
    localparam int MAXC      = 64;
    localparam int WDOG_MAX  = 40000;
    localparam int LONG_HOLD = 500;
    localparam int SETTLE    = 12;
    localparam int RAND_ITEMS = 1050;

    typedef struct {
        logic [7:0] left_pix;
        logic [7:0] right_pix;
        logic       fstart;
    } pix_t;

    typedef struct {
        logic [7:0] disp;
        logic [9:0] arow;
        logic [9:0] acol;
    } disp_t;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, s_tuser;
    logic [15:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [31:0] m_tdata;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    stereo_sad_block_match dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Pending pixels, expected disparities, bookkeeping
    pix_t  pix_q[$];
    disp_t disp_q[$];
    int    send_idle, recv_stall;
    int    errors, n_pixels, n_disp, n_phases;
    logic  hold_go, hold_done;
    int    hold_cnt, wdog;
    logic [7:0] tex[4096];

    // Matcher state mirror
    logic [10:0] cfg_width;
    logic [6:0]  cfg_cands;
    logic [7:0]  cfg_scale;
    logic [7:0]  left_rows[WIN][MAXW];
    logic [7:0]  right_rows[WIN][MAXW];
    int          cur_row, cur_col;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAXW) return MAXW;
        return cfg_width;
    endfunction

    // Store one pixel pair and, for a complete window, compute the winning shift
    task automatic predict_disparity(input pix_t p);
        int w, slot, top, lc, cands, last, best_k, best_sad, sad, val, srow, a, b;
        disp_t e;
        w = eff_width();
        if (p.fstart) begin
            cur_row = 0;
            cur_col = 0;
        end else if (cur_col >= w) begin
            cur_col = 0;
            cur_row = (cur_row + 1) % 1024;
        end
        slot = cur_row % WIN;
        left_rows[slot][cur_col]  = p.left_pix;
        right_rows[slot][cur_col] = p.right_pix;
        if (cur_row >= WIN - 1 && cur_col >= WIN - 1) begin
            top = cur_row - (WIN - 1);
            lc = cur_col - (WIN - 1);
            cands = cfg_cands;
            if (cands < 1) cands = 1;
            if (cands > MAXC) cands = MAXC;
            last = cands - 1;
            if (last > lc) last = lc;
            best_k = 0;
            best_sad = 0;
            for (int k = 0; k <= last; k++) begin
                sad = 0;
                for (int u = 0; u < WIN; u++) begin
                    srow = (top + u) % WIN;
                    for (int v = 0; v < WIN; v++) begin
                        a = left_rows[srow][lc + v];
                        b = right_rows[srow][lc + v - k];
                        sad += (a > b) ? a - b : b - a;
                    end
                end
                if (k == 0 || sad < best_sad) begin
                    best_sad = sad;
                    best_k = k;
                end
            end
            val = best_k * cfg_scale;
            if (val > 255) val = 255;
            e.disp = val[7:0];
            e.arow = top[9:0];
            e.acol = lc[9:0];
            disp_q.insert(disp_q.size(), e);
        end
        cur_col = cur_col + 1;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row = (cur_row + 1) % 1024;
        end
    endtask

    // Input driver: one nonblocking update per signal per edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_disparity('{s_tdata[7:0], s_tdata[15:8], s_tuser});
                n_pixels++;
            end
            if (!s_tvalid || s_tready) begin
                if (pix_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {pix_q[0].right_pix, pix_q[0].left_pix};
                    s_tuser  <= pix_q[0].fstart;
                    void'(pix_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver with random stalls and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            m_tready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= LONG_HOLD) hold_done = 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        disp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_disp++;
            if (disp_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                e = disp_q.pop_front();
                if (m_tdata[7:0] !== e.disp || m_tdata[17:8] !== e.arow
                    || m_tdata[27:18] !== e.acol) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp disp %0d row %0d col %0d, got %0d %0d %0d",
                                 e.disp, e.arow, e.acol, m_tdata[7:0], m_tdata[17:8],
                                 m_tdata[27:18]);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) wdog <= 0;
            else wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("watchdog expired, %0d results outstanding", disp_q.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:     cfg_width = value[10:0];
            REG_CANDIDATE_COUNT: cfg_cands = value[6:0];
            REG_SCALE_FACTOR:    cfg_scale = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int w, input int c, input int s);
        reg_write(REG_IMAGE_WIDTH, w);
        reg_write(REG_CANDIDATE_COUNT, c);
        reg_write(REG_SCALE_FACTOR, s);
    endtask

    // Sender pause: wait until every expected disparity has come back
    task automatic drain();
        wait (pix_q.size() == 0 && !s_tvalid);
        wait (disp_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Frame whose right image is the left image shifted by disp, with some noise
    task automatic push_frame(input int w, input int rows, input int disp,
                              input int noise, input int total);
        pix_t p;
        int r, c;
        for (int i = 0; i < total; i++) begin
            r = i / w;
            c = i % w;
            p.fstart = (i == 0) || ($urandom_range(999) < noise / 4);
            p.left_pix  = tex[(r * 37 + c * 5) & 4095];
            p.right_pix = tex[(r * 37 + (c + disp) * 5) & 4095];
            if ($urandom_range(99) < noise) begin
                p.left_pix  = $urandom_range(255);
                p.right_pix = $urandom_range(255);
            end
            pix_q.insert(pix_q.size(), p);
        end
    endtask

    initial begin
        int mode, w, c, rows, cnt, base;
        pix_t p;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        send_idle = 0; recv_stall = 0; errors = 0; n_pixels = 0; n_disp = 0;
        n_phases = 0; hold_go = 0; hold_done = 0; hold_cnt = 0; wdog = 0;
        cfg_width = IMAGE_WIDTH_RST; cfg_cands = CANDIDATE_COUNT_RST;
        cfg_scale = SCALE_FACTOR_RST; cur_row = 0; cur_col = 0;
        foreach (tex[i]) tex[i] = $urandom_range(255);
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Extreme pixel values, candidate count zero, full scale
        set_config(8, 0, 255);
        for (int i = 0; i < 64; i++) begin
            p.fstart = (i == 0);
            p.left_pix  = (i % 2) ? 8'hFF : 8'h00;
            p.right_pix = ((i / 8 + i) % 2) ? 8'h00 : 8'hFF;
            pix_q.insert(pix_q.size(), p);
        end
        drain();
        // Candidate count above the maximum, zero scale, then a small scale
        set_config(8, 127, 0);
        push_frame(8, 8, 1, 0, 64);
        drain();
        set_config(8, 2, 1);
        push_frame(8, 8, 1, 0, 64);
        drain();
        // Deep search: all 64 shifts on a wide row
        set_config(72, 64, 4);
        push_frame(72, 7, 37, 2, 72 * 7);
        drain();
        // Width zero acts as one
        set_config(0, 15, 15);
        push_frame(1, 1, 0, 50, 64);
        drain();
        // Width above range clamps to the maximum
        set_config(2047, 15, 15);
        push_frame(1024, 1, 0, 50, 64);
        drain();
        // Largest in-range width
        set_config(1024, 64, 255);
        push_frame(1024, 1, 0, 50, 64);
        drain();

        // Random phases cycling through idling modes
        base = n_pixels;
        while (n_pixels - base < RAND_ITEMS) begin
            mode = n_phases % 4;
            send_idle  = (mode == 1 || mode == 3) ? ((mode == 3) ? 26 : 53) : 0;
            recv_stall = (mode == 2 || mode == 3) ? ((mode == 3) ? 26 : 53) : 0;
            w = ($urandom_range(9) == 0) ? $urandom_range(25, 40) : $urandom_range(8, 20);
            c = ($urandom_range(3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 16);
            set_config(w, c, $urandom_range(1) ? $urandom_range(0, 40) : $urandom_range(255));
            rows = $urandom_range(7, 10);
            cnt = ($urandom_range(4) == 0) ? $urandom_range(w, w * rows) : w * rows;
            if (n_phases == 2) begin
                hold_go = 1'b1;
                cnt = w * 10;
            end
            push_frame(w, rows, $urandom_range(0, (c > 20) ? 20 : c),
                       ($urandom_range(3) == 0) ? 40 : 5, cnt);
            drain();
            n_phases++;
        end

        $display("covered %0d pixel pairs, %0d disparities over %0d random phases",
                 n_pixels, n_disp, n_phases);
        $display("%0d mismatches", errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
